// ===== hdl/dwrd_pkg.sv =====
// Package for the daylight window ramp dimmer.
// Holds widths, constants, codes, the controller state type and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package dwrd_pkg;

    localparam int DUTY_FULL_SCALE = 4095;
    localparam int MIN_PER_DAY     = 1440;
    localparam int TWO_DAYS        = 2 * MIN_PER_DAY;
    localparam int DUTY_MAX        = 100;
    localparam int DUTY_MIN        = 2;
    localparam int RAMP_UP_GAIN    = 980;
    localparam int RAMP_DN_GAIN    = 98;
    localparam int PCT_DEN         = 100;

    localparam int MIN_W      = 11;
    localparam int DUR_W      = 11;
    localparam int PERIOD_W   = 8;
    localparam int DUTY_W     = 7;
    localparam int CODE_W     = 12;
    localparam int KIND_W     = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 11;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    localparam int DIVIDEND_W = 21;
    localparam int DIVISOR_W  = 13;
    localparam int QUO_W      = CODE_W;
    localparam int DCNT_W     = $clog2(QUO_W + 1);

    // The compare code is duty * DUTY_FULL_SCALE / PCT_DEN by a rounded-up reciprocal.
    // The product error stays below one count for every 7-bit duty.
    localparam int CODE_SHIFT  = 16;
    localparam int CODE_RECIP  = (DUTY_FULL_SCALE * (1 << CODE_SHIFT) + PCT_DEN - 1) / PCT_DEN;
    localparam int CODE_PROD_W = DUTY_W + $clog2(CODE_RECIP + 1);

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_MANUAL = 2'd1,
        KIND_AUTO   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_MANUAL = 2'd1,
        MODE_AUTO   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CLS_ZERO = 2'd0,
        CLS_FULL = 2'd1,
        CLS_UP   = 2'd2,
        CLS_DOWN = 2'd3
    } t_class;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_START  = 2'd0,
        CFG_END    = 2'd1,
        CFG_DUR    = 2'd2,
        CFG_PERIOD = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TIME,
        ST_SETUP,
        ST_RSTART,
        ST_RWAIT,
        ST_APPLY,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load_item;
        logic calc_time;
        logic setup_ramp;
        logic div_start;
        logic apply;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_sts;

endpackage

// ===== hdl/dwrd_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Depends on dwrd_pkg; the quotient must fit in QUO_W bits.
`timescale 1ns / 1ps

module dwrd_div import dwrd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_busy,
    output logic [QUO_W-1:0]      o_quotient
);

    logic [DIVISOR_W-1:0] r_rem;
    logic [QUO_W-1:0]     r_quo;
    logic [DIVISOR_W-1:0] r_div;
    logic [DCNT_W-1:0]    r_cnt;
    logic [DIVISOR_W:0]   w_sh;
    logic [DIVISOR_W:0]   w_sub;
    logic                 w_ge;

    assign w_sh  = {r_rem, r_quo[QUO_W-1]};
    assign w_ge  = w_sh >= {1'b0, r_div};
    assign w_sub = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DCNT_W'(QUO_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - DCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DIVISOR_W'(i_dividend[DIVIDEND_W-1:QUO_W]);
            r_quo <= i_dividend[QUO_W-1:0];
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_sub[DIVISOR_W-1:0] : w_sh[DIVISOR_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_quo;

endmodule

// ===== hdl/dwrd_dpath.sv =====
// Datapath: configuration registers, item latch, window and ramp arithmetic, lamp state
// and the output register. Depends on dwrd_pkg and dwrd_div.
`timescale 1ns / 1ps

module dwrd_dpath import dwrd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [MIN_W-1:0]      i_minute,
    input  logic                  i_manual_on,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    logic [MIN_W-1:0]      r_start;
    logic [MIN_W-1:0]      r_end;
    logic [DUR_W-1:0]      r_dur;
    logic [PERIOD_W-1:0]   r_period;

    logic [KIND_W-1:0]     r_kind;
    logic [MIN_W-1:0]      r_minute;
    logic                  r_on;

    logic [MIN_W-1:0]      r_t;
    logic                  r_open;
    t_class                r_cls;
    logic [DIVIDEND_W-1:0] r_dividend;
    logic [DIVISOR_W-1:0]  r_divisor;

    t_mode                 r_mode;
    t_mode                 n_mode;
    logic [DUTY_W-1:0]     r_duty;
    logic [DUTY_W-1:0]     n_duty;
    logic                  r_ovr;
    logic                  n_ovr;
    logic [PERIOD_W-1:0]   r_cnt;
    logic [PERIOD_W-1:0]   n_cnt;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [12:0]           w_x;
    logic [12:0]           w_x1;
    logic [12:0]           w_x2;
    logic                  w_wrap;
    logic [11:0]           w_s;
    logic [11:0]           w_e;
    logic [11:0]           w_c;
    logic                  w_open;
    logic [14:0]           w_ten_t;
    logic [DIVISOR_W-1:0]  w_den;
    logic [13:0]           w_seven_d;
    logic [12:0]           w_diff;
    logic [DIVIDEND_W-1:0] w_up_num;
    logic [DIVIDEND_W-1:0] w_dn_num;
    t_class                w_cls;
    logic [QUO_W-1:0]      w_quo;
    logic                  w_busy;
    logic [DUTY_W-1:0]     w_auto_duty;
    logic [PERIOD_W-1:0]   w_cnt_inc;
    logic                  w_sched_hit;
    logic [CODE_PROD_W-1:0] w_code_prod;
    logic [CODE_W-1:0]     w_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= MIN_W'(480);
            r_end    <= MIN_W'(1080);
            r_dur    <= DUR_W'(600);
            r_period <= PERIOD_W'(30);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_START:  r_start  <= i_cfg_wdata[MIN_W-1:0];
                CFG_END:    r_end    <= i_cfg_wdata[MIN_W-1:0];
                CFG_DUR:    r_dur    <= i_cfg_wdata[DUR_W-1:0];
                CFG_PERIOD: r_period <= i_cfg_wdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind   <= i_kind;
            r_minute <= i_minute;
            r_on     <= i_manual_on;
        end
    end

    // Elapsed minutes since the window start, modulo one day, and the window test.
    always_comb begin
        w_x    = 13'(r_minute) + 13'(TWO_DAYS) - 13'(r_start);
        w_x1   = (w_x >= 13'(TWO_DAYS)) ? w_x - 13'(TWO_DAYS) : w_x;
        w_x2   = (w_x1 >= 13'(MIN_PER_DAY)) ? w_x1 - 13'(MIN_PER_DAY) : w_x1;
        w_wrap = r_end < r_start;
        w_s    = 12'(r_start);
        w_e    = w_wrap ? 12'(r_end) + 12'(MIN_PER_DAY) : 12'(r_end);
        w_c    = (w_wrap && (r_minute < r_start)) ? 12'(r_minute) + 12'(MIN_PER_DAY)
                                                  : 12'(r_minute);
        w_open = (w_c >= w_s) && (w_c < w_e);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_time) begin
            r_t    <= w_x2[MIN_W-1:0];
            r_open <= w_open;
        end
    end

    // Ramp segment selection and the dividend for the ramp ratio.
    always_comb begin
        w_ten_t   = 15'({r_t, 3'b000}) + 15'({r_t, 1'b0});
        w_den     = DIVISOR_W'({r_dur, 1'b0}) + DIVISOR_W'(r_dur);
        w_seven_d = 14'({r_dur, 3'b000}) - 14'(r_dur);
        w_diff    = 13'(w_ten_t - 15'(w_seven_d));
        w_up_num  = DIVIDEND_W'(r_t) * DIVIDEND_W'(RAMP_UP_GAIN);
        w_dn_num  = DIVIDEND_W'(w_diff) * DIVIDEND_W'(RAMP_DN_GAIN)
                    + DIVIDEND_W'(w_den) - DIVIDEND_W'(1);
        if (r_dur == '0) begin
            w_cls = CLS_FULL;
        end else if (r_t >= r_dur) begin
            w_cls = CLS_ZERO;
        end else if (w_ten_t <= 15'(w_den)) begin
            w_cls = CLS_UP;
        end else if (w_ten_t <= 15'(w_seven_d)) begin
            w_cls = CLS_FULL;
        end else begin
            w_cls = CLS_DOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup_ramp) begin
            r_cls     <= w_cls;
            r_divisor <= w_den;
            case (w_cls)
                CLS_UP:   r_dividend <= w_up_num;
                CLS_DOWN: r_dividend <= w_dn_num;
                default:  r_dividend <= '0;
            endcase
        end
    end

    dwrd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_dividend),
        .i_divisor  (r_divisor),
        .o_busy     (w_busy),
        .o_quotient (w_quo)
    );

    always_comb begin
        case (r_cls)
            CLS_ZERO: w_auto_duty = '0;
            CLS_UP:   w_auto_duty = DUTY_W'(DUTY_MIN) + w_quo[DUTY_W-1:0];
            CLS_DOWN: w_auto_duty = DUTY_W'(DUTY_MAX) - w_quo[DUTY_W-1:0];
            default:  w_auto_duty = DUTY_W'(DUTY_MAX);
        endcase
    end

    assign w_cnt_inc   = r_cnt + PERIOD_W'(1);
    assign w_sched_hit = r_open != (r_mode != MODE_OFF);

    always_comb begin
        n_mode = r_mode;
        n_duty = r_duty;
        n_ovr  = r_ovr;
        n_cnt  = r_cnt;
        case (t_kind'(r_kind))
            KIND_TICK: begin
                if (!r_ovr && w_sched_hit) begin
                    n_mode = r_open ? MODE_AUTO : MODE_OFF;
                    n_duty = r_open ? w_auto_duty : '0;
                end
                if (w_cnt_inc >= r_period) begin
                    n_cnt = '0;
                    if (!r_ovr && r_open) begin
                        n_duty = w_auto_duty;
                    end
                end else begin
                    n_cnt = w_cnt_inc;
                end
            end
            KIND_MANUAL: begin
                n_ovr  = 1'b1;
                n_mode = r_on ? MODE_MANUAL : MODE_OFF;
                n_duty = r_on ? DUTY_W'(DUTY_MAX) : '0;
            end
            KIND_AUTO: begin
                n_ovr = 1'b0;
                if (w_sched_hit) begin
                    n_mode = r_open ? MODE_AUTO : MODE_OFF;
                    n_duty = r_open ? w_auto_duty : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_OFF;
            r_duty <= '0;
            r_ovr  <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.apply) begin
            r_mode <= n_mode;
            r_duty <= n_duty;
            r_ovr  <= n_ovr;
            r_cnt  <= n_cnt;
        end
    end

    assign w_code_prod = CODE_PROD_W'(r_duty) * CODE_PROD_W'(CODE_RECIP);
    assign w_code      = w_code_prod[CODE_SHIFT +: CODE_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {1'b0, r_ovr, 2'(r_mode), w_code, r_duty, r_mode != MODE_OFF};
        end
    end

    assign o_sts.div_busy = w_busy;
    assign o_out_data     = r_out_data;

endmodule

// ===== hdl/dwrd_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
// Depends on dwrd_pkg; drives commands to dwrd_dpath and owns the output valid flag.
`timescale 1ns / 1ps

module dwrd_ctrl import dwrd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    input  logic i_m_tready,
    input  t_sts i_sts,
    output logic o_s_tready,
    output logic o_m_tvalid,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_s_tvalid) n_state = ST_TIME;
            ST_TIME:   n_state = ST_SETUP;
            ST_SETUP:  n_state = ST_RSTART;
            ST_RSTART: n_state = ST_RWAIT;
            ST_RWAIT:  if (!i_sts.div_busy) n_state = ST_APPLY;
            ST_APPLY:  n_state = ST_OUT;
            ST_OUT:    if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready      = 1'b1;
                o_cmd.load_item = i_s_tvalid;
            end
            ST_TIME:   o_cmd.calc_time  = 1'b1;
            ST_SETUP:  o_cmd.setup_ramp = 1'b1;
            ST_RSTART: o_cmd.div_start  = 1'b1;
            ST_APPLY:  o_cmd.apply      = 1'b1;
            ST_OUT:    o_cmd.out_load   = w_out_free;
            default: ;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

// ===== hdl/daylight_window_ramp_dimmer_top.sv =====
// Top level of the daylight window ramp dimmer.
// Depends on dwrd_pkg, dwrd_ctrl, dwrd_dpath and dwrd_div.
//
// The input stream carries one item per transfer: a tick with the
// minute of day, a manual on/off set, or a return to automatic mode. Every
// accepted item gives exactly one status transfer on the output stream with
// the lamp switch level, duty in percent, the 12-bit duty compare code, the
// lamp mode and the manual override flag as they stand after the item.
// An item passes through ST_TIME, ST_SETUP, ST_RSTART, ST_RWAIT, ST_APPLY and
// ST_OUT from its transfer to a valid result, and the next item can be taken
// in the cycle the result appears, not before. Most of that time is the serial
// divider for the ramp ratio, which ST_RWAIT waits on until it is no longer
// busy. The duty compare code is a constant multiplication in the output cycle.
// The configuration port writes one register per cycle and should be used
// only while no item is in flight.
// Reset is synchronous: the lamp is off, the duty is zero, automation is
// active, the refresh counter is cleared and the configuration registers
// return to their defaults. When the receiver stalls, the result waits in the
// output register and one more item is taken and processed; that item then
// waits until the output register is free.
`timescale 1ns / 1ps

module daylight_window_ramp_dimmer_top import dwrd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // minute_of_day [10:0], manual_on [11], zero [15:12]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind [1:0]
    input  logic [KIND_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // lamp_switch [0], duty_pct [7:1], duty_code [19:8], lamp_mode [21:20],
    // manual_active [22], zero [23]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cmd w_cmd;
    t_sts w_sts;

    dwrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_sts      (w_sts),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_cmd      (w_cmd)
    );

    dwrd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_kind      (s_axis_tuser),
        .i_minute    (s_axis_tdata[MIN_W-1:0]),
        .i_manual_on (s_axis_tdata[MIN_W]),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_data  (m_axis_tdata)
    );

`ifndef NO_ASSERTIONS
    a_one_item_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken twice in a row");

    a_switch_matches_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[21:20] != 2'(MODE_OFF))))
        else $error("lamp switch disagrees with lamp mode");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:1] <= 7'(DUTY_MAX)))
        else $error("duty above full scale");

    a_override_not_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[22] |-> (m_axis_tdata[21:20] != 2'(MODE_AUTO)))
        else $error("automatic mode reported under manual override");
`endif

endmodule
